// ----- rtl/triangle_tangent_from_uv_macros.svh -----
// Assertion macros shared by the tangent block RTL.
// Expects signals named clk and rst in the scope of use.
`ifndef TRIANGLE_TANGENT_FROM_UV_MACROS_SVH
`define TRIANGLE_TANGENT_FROM_UV_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TFT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tangent block: assertion failed");
// next-cycle implication
`define TFT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tangent block: assertion failed");
`else
`define TFT_ASSERT_IMP(lbl, ante, cons)
`define TFT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/tft_pkg.sv -----
// Shared constants, state encoding and controller/datapath interface types
// for the triangle tangent block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tft_pkg;

  // default geometry
  localparam int COORD_WIDTH     = 16;
  localparam int RESULT_FRACTION = 16;

  // fixed result format, signed Q16.16 in 32 bits
  localparam int RESULT_WIDTH = 32;
  localparam int AXES         = 3;
  localparam logic [RESULT_WIDTH-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [RESULT_WIDTH-1:0] Q_MIN = 32'h8000_0000;

  // divider: quotient bits resolved per cycle
  localparam int QBITS_PER_STEP = 2;
  localparam int DIV_STEPS      = RESULT_WIDTH / QBITS_PER_STEP;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  // tuser bit positions on the result channel
  localparam int USER_DEGEN = 0;
  localparam int USER_SAT   = 1;

  typedef enum logic [3:0] {
    S_GATHER,
    S_DET_MUL,
    S_DET,
    S_NUM_MUL,
    S_NUM,
    S_CHECK,
    S_DIV,
    S_STORE,
    S_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       cap_first;
    logic       cap_second;
    logic       cap_third;
    logic       det_mul;
    logic       det_sub;
    logic       num_mul;
    logic       num_sub;
    logic       div_init;
    logic       div_step;
    logic       store;
    logic       load_out;
    logic [1:0] axis;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic det_zero;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/tft_datapath.sv -----
// Datapath of the tangent block: vertex store, edge/UV deltas, shared
// multiplier pair, restoring divider and output register. Uses tft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tft_datapath #(
  parameter int COORD_WIDTH     = tft_pkg::COORD_WIDTH,
  parameter int RESULT_FRACTION = tft_pkg::RESULT_FRACTION
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic [5*COORD_WIDTH-1:0]                     in_data,
  input  tft_pkg::cmd_t                                cmd,
  output tft_pkg::sts_t                                sts,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [tft_pkg::AXES*tft_pkg::RESULT_WIDTH-1:0] out_tangent,
  output logic                                         out_degen,
  output logic                                         out_sat
);

  localparam int CW   = COORD_WIDTH;
  localparam int RW   = tft_pkg::RESULT_WIDTH;
  localparam int DW   = CW + 1;          // delta width
  localparam int PW   = 2 * DW;          // product width
  localparam int NW   = PW + 1;          // det / numerator width
  localparam int EXTW = NW + RESULT_FRACTION + RW;

  function automatic logic signed [DW-1:0] sx(input logic signed [CW-1:0] a);
    return {a[CW-1], a};
  endfunction

  // unpacked input beat
  logic signed [CW-1:0] in_pos [3];
  logic signed [CW-1:0] in_uv  [2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_pos[k] = in_data[k*CW +: CW];
    end
    in_uv[0] = in_data[3*CW +: CW];
    in_uv[1] = in_data[4*CW +: CW];
  end

  // stored vertices and deltas
  logic signed [CW-1:0] first_pos  [3];
  logic signed [CW-1:0] first_uv   [2];
  logic signed [CW-1:0] second_pos [3];
  logic signed [CW-1:0] second_uv  [2];
  logic signed [DW-1:0] e1 [3];
  logic signed [DW-1:0] e2 [3];
  logic signed [DW-1:0] d1u, d1v, d2u, d2v;

  // products and magnitudes
  logic signed [PW-1:0] prod_a, prod_b;
  logic [NW-1:0]        diff, diff_mag;
  logic [NW-1:0]        det_mag, num_mag;
  logic                 det_neg, det_zero, num_neg;

  // divider
  logic [EXTW-1:0] num_ext;
  logic [NW-1:0]   ext_hi;
  logic [RW-1:0]   ext_lo;
  logic [NW-1:0]   rem, rem_next;
  logic [RW-1:0]   quo, quo_next;
  logic            ovf;

  // per-axis result
  logic [RW-1:0] res [3];
  logic [RW-1:0] val;
  logic          sat_now, sat_acc, neg;

  // difference of the two products, sign extended
  assign diff     = {prod_a[PW-1], prod_a} - {prod_b[PW-1], prod_b};
  assign diff_mag = diff[NW-1] ? (~diff + 1'b1) : diff;

  // numerator scaled by 2^RESULT_FRACTION, split at the quotient width
  assign num_ext = {{(RESULT_FRACTION + RW){1'b0}}, num_mag} << RESULT_FRACTION;
  assign ext_lo  = num_ext[RW-1:0];
  assign ext_hi  = num_ext[RW +: NW];

  // restoring division, QBITS_PER_STEP bits per cycle
  always_comb begin
    logic [NW:0] t;
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < tft_pkg::QBITS_PER_STEP; i++) begin
      t        = {rem_next, quo_next[RW-1]};
      quo_next = {quo_next[RW-2:0], 1'b0};
      if (t >= {1'b0, det_mag}) begin
        t           = t - {1'b0, det_mag};
        quo_next[0] = 1'b1;
      end
      rem_next = t[NW-1:0];
    end
  end

  // sign and clamp of the finished quotient
  assign neg = num_neg ^ det_neg;

  always_comb begin
    sat_now = 1'b0;
    val     = quo;
    priority if (ovf) begin
      sat_now = 1'b1;
      val     = neg ? tft_pkg::Q_MIN : tft_pkg::Q_MAX;
    end else if (neg) begin
      if (quo > tft_pkg::Q_MIN) begin
        sat_now = 1'b1;
        val     = tft_pkg::Q_MIN;
      end else begin
        val = ~quo + 1'b1;
      end
    end else if (quo[RW-1]) begin
      sat_now = 1'b1;
      val     = tft_pkg::Q_MAX;
    end else begin
      val = quo;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap_first) begin
      for (int k = 0; k < 3; k++) first_pos[k] <= in_pos[k];
      first_uv[0] <= in_uv[0];
      first_uv[1] <= in_uv[1];
    end
    if (cmd.cap_second) begin
      for (int k = 0; k < 3; k++) second_pos[k] <= in_pos[k];
      second_uv[0] <= in_uv[0];
      second_uv[1] <= in_uv[1];
    end
    if (cmd.cap_third) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] <= sx(second_pos[k]) - sx(first_pos[k]);
        e2[k] <= sx(in_pos[k]) - sx(first_pos[k]);
      end
      d1u <= sx(second_uv[0]) - sx(first_uv[0]);
      d1v <= sx(second_uv[1]) - sx(first_uv[1]);
      d2u <= sx(in_uv[0]) - sx(first_uv[0]);
      d2v <= sx(in_uv[1]) - sx(first_uv[1]);
    end
    if (cmd.det_mul) begin
      prod_a <= d1u * d2v;
      prod_b <= d2u * d1v;
    end
    if (cmd.num_mul) begin
      prod_a <= d2v * e1[cmd.axis];
      prod_b <= d1v * e2[cmd.axis];
    end
    if (cmd.det_sub) begin
      det_mag  <= diff_mag;
      det_neg  <= diff[NW-1];
      det_zero <= (diff == '0);
      sat_acc  <= 1'b0;
    end
    if (cmd.num_sub) begin
      num_mag <= diff_mag;
      num_neg <= diff[NW-1];
    end
    if (cmd.div_init) begin
      rem <= ext_hi;
      quo <= ext_lo;
      ovf <= (ext_hi >= det_mag);
    end
    if (cmd.div_step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
    if (cmd.store) begin
      res[cmd.axis] <= val;
      sat_acc       <= sat_acc | sat_now;
    end
    if (cmd.load_out) begin
      out_tangent <= det_zero ? '0 : {res[2], res[1], res[0]};
      out_degen   <= det_zero;
      out_sat     <= ~det_zero & sat_acc;
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.det_zero = det_zero;
  assign sts.out_free = ~out_valid | out_ready;

endmodule

`default_nettype wire

// ----- rtl/tft_ctrl.sv -----
// Controller of the tangent block: vertex slot tracking and the sequence
// of multiply, subtract and divide steps. Uses tft_pkg and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_tangent_from_uv_macros.svh"

module tft_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output tft_pkg::cmd_t cmd,
  input  tft_pkg::sts_t sts
);

  typedef enum logic [1:0] {
    SLOT_FIRST,
    SLOT_SECOND,
    SLOT_THIRD
  } slot_t;

  localparam logic [1:0] AXIS_LAST = 2'(tft_pkg::AXES - 1);
  localparam logic [tft_pkg::DIV_CNT_W-1:0] DIV_LAST =
    tft_pkg::DIV_CNT_W'(tft_pkg::DIV_STEPS - 1);

  tft_pkg::state_t              state, state_next;
  slot_t                        slot, slot_next;
  logic [1:0]                   axis, axis_next;
  logic [tft_pkg::DIV_CNT_W-1:0] div_cnt, div_cnt_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tft_pkg::S_GATHER;
      slot    <= SLOT_FIRST;
      axis    <= '0;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      slot    <= slot_next;
      axis    <= axis_next;
      div_cnt <= div_cnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    slot_next    = slot;
    axis_next    = axis;
    div_cnt_next = div_cnt;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.axis     = axis;
    unique case (state)
      tft_pkg::S_GATHER: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (slot)
            SLOT_SECOND: begin
              cmd.cap_second = 1'b1;
              slot_next      = SLOT_THIRD;
            end
            SLOT_THIRD: begin
              cmd.cap_third = 1'b1;
              slot_next     = SLOT_FIRST;
              state_next    = tft_pkg::S_DET_MUL;
            end
            default: begin
              cmd.cap_first = 1'b1;
              slot_next     = SLOT_SECOND;
            end
          endcase
        end
      end
      tft_pkg::S_DET_MUL: begin
        cmd.det_mul = 1'b1;
        state_next  = tft_pkg::S_DET;
      end
      tft_pkg::S_DET: begin
        cmd.det_sub = 1'b1;
        axis_next   = '0;
        state_next  = tft_pkg::S_NUM_MUL;
      end
      tft_pkg::S_NUM_MUL: begin
        // degenerate triangle skips the division
        if (sts.det_zero) begin
          state_next = tft_pkg::S_FINISH;
        end else begin
          cmd.num_mul = 1'b1;
          state_next  = tft_pkg::S_NUM;
        end
      end
      tft_pkg::S_NUM: begin
        cmd.num_sub = 1'b1;
        state_next  = tft_pkg::S_CHECK;
      end
      tft_pkg::S_CHECK: begin
        cmd.div_init = 1'b1;
        div_cnt_next = '0;
        state_next   = tft_pkg::S_DIV;
      end
      tft_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = tft_pkg::S_STORE;
        end
      end
      tft_pkg::S_STORE: begin
        cmd.store = 1'b1;
        if (axis == AXIS_LAST) begin
          state_next = tft_pkg::S_FINISH;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = tft_pkg::S_NUM_MUL;
        end
      end
      tft_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = tft_pkg::S_GATHER;
        end
      end
      default: begin
        state_next = tft_pkg::S_GATHER;
      end
    endcase
  end

  // checks
  `TFT_ASSERT_NXT(a_third_starts, state == tft_pkg::S_GATHER && in_valid && slot == SLOT_THIRD, state == tft_pkg::S_DET_MUL)
  `TFT_ASSERT_NXT(a_div_done, state == tft_pkg::S_DIV && div_cnt == DIV_LAST, state == tft_pkg::S_STORE)
  `TFT_ASSERT_IMP(a_load_free, cmd.load_out, sts.out_free)

endmodule

`default_nettype wire

// ----- rtl/triangle_tangent_from_uv.sv -----
// Top level of the triangle tangent block: stream ports, controller and
// datapath. Uses tft_pkg, tft_ctrl, tft_datapath and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_tangent_from_uv_macros.svh"

// Vertices arrive one beat at a time, three per triangle; the third beat of
// each triangle yields one result beat with the tangent in signed Q16.16,
// truncated toward zero and clamped, plus degenerate and saturated flags.
// The first two vertices of a triangle are taken while the block gathers.
// After the third, the block stays busy (it skips the division when the UV
// determinant is zero) before it takes the next vertex of the next triangle:
// the shared restoring divider resolves two quotient bits a cycle for each
// of the three axes, with multiply, subtract, range check and store steps
// around each division.
// A finished result waits in its own output register, so the last step
// completes as soon as that register is free.
module triangle_tangent_from_uv #(
  parameter int COORD_WIDTH     = tft_pkg::COORD_WIDTH,
  parameter int RESULT_FRACTION = tft_pkg::RESULT_FRACTION
) (
  input  logic clk,
  input  logic rst,
  // vertex channel
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata, low bit up: pos_x, pos_y, pos_z, tex_u, tex_v, zero pad
  input  logic [((5*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  // result channel
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata, low bit up: tangent_x, tangent_y, tangent_z
  output logic [tft_pkg::AXES*tft_pkg::RESULT_WIDTH-1:0] m_axis_tdata,
  // tuser, low bit up: degenerate, saturated
  output logic [1:0]                           m_axis_tuser
);

  tft_pkg::cmd_t cmd;
  tft_pkg::sts_t sts;
  logic          degen, sat;

  tft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  tft_datapath #(
    .COORD_WIDTH     (COORD_WIDTH),
    .RESULT_FRACTION (RESULT_FRACTION)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_data     (s_axis_tdata[5*COORD_WIDTH-1:0]),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_tangent (m_axis_tdata),
    .out_degen   (degen),
    .out_sat     (sat)
  );

  // result flags
  always_comb begin
    m_axis_tuser                      = '0;
    m_axis_tuser[tft_pkg::USER_DEGEN] = degen;
    m_axis_tuser[tft_pkg::USER_SAT]   = sat;
  end

  // a degenerate result carries zero tangent and no clamp
  `TFT_ASSERT_IMP(a_degen_zero, m_axis_tvalid && m_axis_tuser[tft_pkg::USER_DEGEN], m_axis_tdata == '0 && !m_axis_tuser[tft_pkg::USER_SAT])

endmodule

`default_nettype wire
